// ===== sv/tre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tre_pkg: shared types and constants of the TFTP receive engine
// Item codes, packet codes, beat payload structs and the block size.
// ----------------------------------------------------------------------------
package tre_pkg;

   // payload bytes in a full data block
   localparam logic [15:0] BLOCK_BYTES = 16'd512;

   // header bytes in front of the payload
   localparam logic [15:0] HDR_BYTES = 16'd4;
   localparam logic [15:0] MIN_BYTES = 16'd2;

   localparam logic [15:0] PKT_DATA  = 16'd3;
   localparam logic [15:0] PKT_ERROR = 16'd5;

   localparam logic [31:0] SIZE_LIMIT_RESET = 32'd16777216;
   localparam logic [15:0] FIRST_BLOCK      = 16'd1;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_PACKET  = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_SUCCESS = 2'd1,
      ST_FAILURE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] packet_type;
      logic [15:0] block_number;
      logic [15:0] app_length;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        send_ack;
      logic [15:0] ack_block;
      logic        resend_request;
      logic        store_data;
      logic [31:0] store_offset;
      logic [9:0]  store_length;
      logic [31:0] received_total;
   } rsp_payload_type;

   // input stage toward the core
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } stage_type;

endpackage
`default_nettype wire

// ===== sv/tre_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tre_ifs: valid/ready channels of the TFTP receive engine
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface tre_req_if;
   logic                     valid;
   logic                     ready;
   tre_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tre_rsp_if;
   logic                     valid;
   logic                     ready;
   tre_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tre_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/tftp_receive_engine.sv =====
`default_nettype none
// The engine takes one request beat per clock while the response side is not
// stalled, and returns exactly one response beat for each, in order, after the
// beat passes through the request register and then the result register.
// Transfer state (status, expected block, byte total) is updated in
// the same cycle the result is registered, so back-to-back beats see each
// other's effect with no bubble. req_chan.ready follows rsp_chan.ready through
// the two stages; the size limit register is written through csr_chan, which is
// always ready. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// tftp_receive_engine: receive side of a TFTP read transfer
// Request register, transfer decode and result register.
// ----------------------------------------------------------------------------
module tftp_receive_engine (
   input wire logic  clock,
   input wire logic  reset,
   tre_req_if.sink   req_chan,
   tre_rsp_if.source rsp_chan,
   tre_csr_if.sink   csr_chan
);

   // staged request beat and backpressure from the core
   tre_pkg::stage_type stage;
   logic               core_ready;

   tre_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .core_ready (core_ready),
      .stage      (stage)
   );

   // decode, transfer state, size limit and result register
   tre_core u_core (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .core_ready (core_ready),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan)
   );

endmodule
`default_nettype wire

// ===== sv/tre_input_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tre_input_stage: request beat register
// Captures one request beat; advances whenever the core takes it.
// ----------------------------------------------------------------------------
module tre_input_stage (
   input  wire logic          clock,
   input  wire logic          reset,
   tre_req_if.sink            req_chan,
   input  wire logic          core_ready,
   output tre_pkg::stage_type stage
);

   logic                     valid_ff;
   logic                     valid_in;
   tre_pkg::req_payload_type data_ff;
   logic                     take;

   assign req_chan.ready = !valid_ff || core_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !core_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_chan.payload;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.payload = data_ff;

endmodule
`default_nettype wire

// ===== sv/tre_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tre_core: transfer state and result register
// Decodes the staged beat against the transfer state, registers the result.
// ----------------------------------------------------------------------------
module tre_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tre_pkg::stage_type stage,
   output logic               core_ready,
   tre_rsp_if.source          rsp_chan,
   tre_csr_if.sink            csr_chan
);

   tre_pkg::status_type      state_ff, state_in;
   logic [15:0]              block_ff, block_in;
   logic [31:0]              total_ff, total_in;
   logic [31:0]              limit_ff;
   logic                     rsp_valid_ff;
   tre_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic            load;
   logic [15:0]     pay_len;
   logic [32:0]     sum;
   logic            len_ok, is_error, data_ok, over, accept, full_blk, pending;
   tre_pkg::op_type op;

   assign csr_chan.ready = 1'b1;
   assign core_ready     = !rsp_valid_ff || rsp_chan.ready;
   assign load           = stage.valid && core_ready;

   assign op       = tre_pkg::op_type'(stage.payload.opcode);
   assign pending  = (state_ff == tre_pkg::ST_PENDING);
   assign pay_len  = stage.payload.app_length - tre_pkg::HDR_BYTES;
   assign len_ok   = stage.payload.app_length >= tre_pkg::MIN_BYTES;
   assign is_error = len_ok && (stage.payload.packet_type == tre_pkg::PKT_ERROR);
   assign data_ok  = len_ok && (stage.payload.packet_type == tre_pkg::PKT_DATA)
                     && (stage.payload.app_length >= tre_pkg::HDR_BYTES)
                     && (stage.payload.block_number == block_ff)
                     && (pay_len <= tre_pkg::BLOCK_BYTES);
   assign sum      = {1'b0, total_ff} + {17'b0, pay_len};
   assign over     = sum > {1'b0, limit_ff};
   assign accept   = data_ok && !over;
   assign full_blk = (pay_len == tre_pkg::BLOCK_BYTES);

   // next transfer state
   always_comb begin
      state_in = state_ff;
      block_in = block_ff;
      total_in = total_ff;
      case (op)
         tre_pkg::OP_START: begin
            state_in = tre_pkg::ST_PENDING;
            block_in = tre_pkg::FIRST_BLOCK;
            total_in = 32'd0;
         end
         tre_pkg::OP_PACKET: begin
            if (pending) begin
               if (is_error || (data_ok && over)) begin
                  state_in = tre_pkg::ST_FAILURE;
               end else if (accept) begin
                  total_in = sum[31:0];
                  if (full_blk) begin
                     block_in = block_ff + 16'd1;
                  end else begin
                     state_in = tre_pkg::ST_SUCCESS;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // result fields
   always_comb begin
      rsp_in = '0;
      case (op)
         tre_pkg::OP_PACKET: begin
            if (pending && accept) begin
               rsp_in.store_data   = (pay_len != 16'd0);
               rsp_in.store_offset = total_ff;
               rsp_in.store_length = pay_len[9:0];
               if (full_blk) begin
                  rsp_in.send_ack  = 1'b1;
                  rsp_in.ack_block = block_ff;
               end
            end
         end
         tre_pkg::OP_TIMEOUT: begin
            if (pending) begin
               if (block_ff == tre_pkg::FIRST_BLOCK) begin
                  rsp_in.resend_request = 1'b1;
               end else begin
                  rsp_in.send_ack  = 1'b1;
                  rsp_in.ack_block = block_ff - 16'd1;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_in.status         = state_in;
      rsp_in.received_total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tre_pkg::ST_PENDING;
         block_ff     <= tre_pkg::FIRST_BLOCK;
         total_ff     <= 32'd0;
         limit_ff     <= tre_pkg::SIZE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            state_ff <= state_in;
            block_ff <= block_in;
            total_ff <= total_in;
         end
         if (csr_chan.valid) begin
            limit_ff <= csr_chan.data;
         end
         if (core_ready) begin
            rsp_valid_ff <= stage.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   a_ack_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.send_ack |-> rsp_ff.status == tre_pkg::ST_PENDING)
      else $error("ack issued on a finished transfer");

   a_store_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.store_data |->
         rsp_ff.received_total == rsp_ff.store_offset + {22'b0, rsp_ff.store_length})
      else $error("received total does not follow stored payload");

   a_resend_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.resend_request |-> !rsp_ff.send_ack && !rsp_ff.store_data)
      else $error("request resend mixed with ack or store");

   a_done_frozen: assert property (@(posedge clock) disable iff (reset)
      load && !pending && op != tre_pkg::OP_START |=> $stable(total_ff) && $stable(block_ff))
      else $error("finished transfer changed its counters");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the TFTP receive engine
// Drives request beats and size limit writes, predicts each response beat
// from a local model of the transfer state, and checks them in order while
// both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          RANDOM_BEATS = 1780;
   localparam logic [15:0] FULL_LEN     = tre_pkg::BLOCK_BYTES + tre_pkg::HDR_BYTES;

   logic clock;
   logic reset;

   tre_req_if req_if ();
   tre_rsp_if rsp_if ();
   tre_csr_if csr_if ();

   tftp_receive_engine DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   // local copy of the transfer state and the size limit
   tre_pkg::status_type xfer_state;
   logic [15:0]         next_block;
   logic [31:0]         bytes_seen;
   logic [31:0]         size_lim;

   // responses owed by the engine, oldest first
   tre_pkg::rsp_payload_type rsp_due[$];

   int fault_count;
   int cycle_count;
   bit steady;      // no idling on either side while set
   int hold_left;   // receiver hold-off, in cycles

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Next response for one accepted request beat; updates the local state.
   function automatic tre_pkg::rsp_payload_type predict_rsp(tre_pkg::req_payload_type r);
      tre_pkg::rsp_payload_type e;
      logic [15:0]              pay;
      logic [32:0]              sum;
      e = '0;
      case (tre_pkg::op_type'(r.opcode))
         tre_pkg::OP_START: begin
            xfer_state = tre_pkg::ST_PENDING;
            next_block = tre_pkg::FIRST_BLOCK;
            bytes_seen = '0;
         end
         tre_pkg::OP_PACKET: begin
            // short packets are dropped before the type is even looked at
            if (xfer_state == tre_pkg::ST_PENDING && r.app_length >= tre_pkg::MIN_BYTES) begin
               if (r.packet_type == tre_pkg::PKT_ERROR) begin
                  xfer_state = tre_pkg::ST_FAILURE;
               end else if (r.packet_type == tre_pkg::PKT_DATA &&
                            r.app_length >= tre_pkg::HDR_BYTES &&
                            r.block_number == next_block) begin
                  pay = r.app_length - tre_pkg::HDR_BYTES;
                  if (pay <= tre_pkg::BLOCK_BYTES) begin
                     // limit compare is done without wrap
                     sum = {1'b0, bytes_seen} + {17'b0, pay};
                     if (sum > {1'b0, size_lim}) begin
                        xfer_state = tre_pkg::ST_FAILURE;
                     end else begin
                        e.store_data   = (pay != 16'd0);
                        e.store_offset = bytes_seen;
                        e.store_length = pay[9:0];
                        bytes_seen     = sum[31:0];
                        if (pay < tre_pkg::BLOCK_BYTES) begin
                           xfer_state = tre_pkg::ST_SUCCESS;
                        end else begin
                           e.send_ack  = 1'b1;
                           e.ack_block = next_block;
                           next_block  = next_block + 16'd1;
                        end
                     end
                  end
               end
            end
         end
         tre_pkg::OP_TIMEOUT: begin
            if (xfer_state == tre_pkg::ST_PENDING) begin
               if (next_block == tre_pkg::FIRST_BLOCK) begin
                  e.resend_request = 1'b1;
               end else begin
                  e.send_ack  = 1'b1;
                  e.ack_block = next_block - 16'd1;
               end
            end
         end
         default: ;
      endcase
      e.status         = xfer_state;
      e.received_total = bytes_seen;
      return e;
   endfunction

   function automatic tre_pkg::req_payload_type make_req(tre_pkg::op_type op,
                                                         logic [15:0] ptype,
                                                         logic [15:0] blk,
                                                         logic [15:0] len);
      tre_pkg::req_payload_type r;
      r.opcode       = op;
      r.packet_type  = ptype;
      r.block_number = blk;
      r.app_length   = len;
      return r;
   endfunction

   // One request beat. valid stays high on return so the next beat can follow
   // back to back; whoever stops sending lowers it at a later falling edge.
   task automatic send_beat(tre_pkg::req_payload_type r);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 7) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      rsp_due.push_back(predict_rsp(r));
   endtask

   task automatic send_pkt(logic [15:0] ptype, logic [15:0] blk, logic [15:0] len);
      send_beat(make_req(tre_pkg::OP_PACKET, ptype, blk, len));
   endtask

   task automatic send_op(tre_pkg::op_type op);
      send_beat(make_req(op, 16'($urandom), 16'($urandom), 16'($urandom)));
   endtask

   // Register write, only with the engine drained.
   task automatic write_size_limit(logic [31:0] v);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= v;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      size_lim = v;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Before any start: timeout asks for the request again, NOP does nothing.
   task automatic test_after_reset();
      send_op(tre_pkg::OP_TIMEOUT);
      send_op(tre_pkg::OP_NOP);
   endtask

   // Runt, non-data, wrong-block and oversized packets all leave state alone.
   task automatic test_ignored_packets();
      send_op(tre_pkg::OP_START);
      send_pkt(tre_pkg::PKT_ERROR, 16'd1, 16'd0);
      send_pkt(tre_pkg::PKT_ERROR, 16'd1, 16'd1);
      send_pkt(tre_pkg::PKT_DATA, 16'd1, 16'd3);
      send_pkt(16'hFFFF, 16'd1, FULL_LEN);
      send_pkt(tre_pkg::PKT_DATA, 16'hFFFF, FULL_LEN);
      send_pkt(tre_pkg::PKT_DATA, 16'd1, 16'hFFFF);
   endtask

   // Full block acked, timeout resends that ack, short block finishes;
   // after that packets and timeouts are ignored.
   task automatic test_full_then_short();
      send_op(tre_pkg::OP_START);
      send_pkt(tre_pkg::PKT_DATA, 16'd1, FULL_LEN);
      send_op(tre_pkg::OP_TIMEOUT);
      send_pkt(tre_pkg::PKT_DATA, 16'd2, 16'd104);
      send_pkt(tre_pkg::PKT_DATA, 16'd3, FULL_LEN);
      send_op(tre_pkg::OP_TIMEOUT);
   endtask

   task automatic test_error_and_empty();
      send_op(tre_pkg::OP_START);
      send_pkt(tre_pkg::PKT_ERROR, 16'd0, 16'd2);
      // empty final block: success with nothing stored
      send_op(tre_pkg::OP_START);
      send_pkt(tre_pkg::PKT_DATA, 16'd1, tre_pkg::HDR_BYTES);
   endtask

   task automatic test_size_limit();
      write_size_limit(32'd0);
      send_op(tre_pkg::OP_START);
      send_pkt(tre_pkg::PKT_DATA, 16'd1, FULL_LEN);
      // exactly at the limit is still fine
      write_size_limit(32'd1024);
      send_op(tre_pkg::OP_START);
      send_pkt(tre_pkg::PKT_DATA, 16'd1, FULL_LEN);
      send_pkt(tre_pkg::PKT_DATA, 16'd2, FULL_LEN);
      // limit lowered below the running total: even an empty block fails
      write_size_limit(32'd1000);
      send_pkt(tre_pkg::PKT_DATA, 16'd3, tre_pkg::HDR_BYTES);
   endtask

   // Receiver holds off for a long stretch; the sender keeps offering beats.
   task automatic test_backpressure();
      write_size_limit(tre_pkg::SIZE_LIMIT_RESET);
      send_op(tre_pkg::OP_START);
      hold_left = 200;
      repeat (40) send_pkt(tre_pkg::PKT_DATA, next_block, FULL_LEN);
      send_pkt(tre_pkg::PKT_DATA, next_block, 16'd5);
   endtask

   // Mostly well-formed transfers with random sizes, salted with noise.
   task automatic test_random_transfers();
      int          sent;
      int          r;
      int          fulls;
      int          burst;
      logic [31:0] lim;
      sent   = 0;
      steady = 1'b1;
      while (sent < RANDOM_BEATS) begin
         if (steady && sent >= 250) steady = 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0:       lim = '0;
               1:       lim = '1;
               2:       lim = tre_pkg::SIZE_LIMIT_RESET;
               3:       lim = $urandom_range(0, 6000);
               default: lim = $urandom;
            endcase
            write_size_limit(lim);
         end
         send_op(tre_pkg::OP_START);
         sent++;
         fulls = $urandom_range(0, 10);
         burst = 0;
         while (xfer_state == tre_pkg::ST_PENDING && burst < 60) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
               if (fulls > 0) begin
                  send_pkt(tre_pkg::PKT_DATA, next_block, FULL_LEN);
                  fulls--;
               end else begin
                  send_pkt(tre_pkg::PKT_DATA, next_block, 16'($urandom_range(4, 515)));
               end
            end else if (r < 80) begin
               send_op(tre_pkg::OP_TIMEOUT);
            end else if (r < 85) begin
               send_pkt(tre_pkg::PKT_DATA, next_block ^ (16'd1 << $urandom_range(0, 15)),
                        FULL_LEN);
            end else if (r < 89) begin
               send_pkt(16'($urandom), 16'($urandom), 16'($urandom));
            end else if (r < 92) begin
               send_pkt($urandom_range(0, 1) ? tre_pkg::PKT_DATA : tre_pkg::PKT_ERROR,
                        next_block, 16'($urandom_range(0, 3)));
            end else if (r < 94) begin
               send_pkt(tre_pkg::PKT_DATA, next_block, 16'($urandom_range(517, 65535)));
            end else if (r < 96) begin
               send_pkt(tre_pkg::PKT_ERROR, 16'($urandom), 16'($urandom_range(2, 65535)));
            end else if (r < 98) begin
               send_op(tre_pkg::OP_NOP);
            end else begin
               send_beat(make_req(tre_pkg::op_type'($urandom_range(0, 3)), 16'($urandom),
                                  16'($urandom), 16'($urandom)));
            end
            sent++;
            burst++;
         end
         // poke the finished transfer now and then
         if ($urandom_range(0, 2) == 0) begin
            send_op(tre_pkg::OP_TIMEOUT);
            sent++;
         end
         if ($urandom_range(0, 2) == 0) begin
            send_pkt(tre_pkg::PKT_DATA, next_block, FULL_LEN);
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------ processes

   // Receiver side: random stalls, hold-off when asked, calm while steady.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(0, 99) >= 7);
         end
      end
   end

   // Response checker: every beat against the oldest prediction.
   always @(posedge clock) begin
      tre_pkg::rsp_payload_type want;
      tre_pkg::rsp_payload_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = rsp_if.payload;
         if (rsp_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("response beat with nothing due: %p", got);
         end else begin
            want = rsp_due.pop_front();
            if (got.status !== want.status || got.send_ack !== want.send_ack ||
                got.ack_block !== want.ack_block ||
                got.resend_request !== want.resend_request ||
                got.store_data !== want.store_data ||
                got.store_offset !== want.store_offset ||
                got.store_length !== want.store_length ||
                got.received_total !== want.received_total) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: expected %p", want);
                  $display("          actual   %p", got);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tftp_receive_engine test failed");
         $finish;
      end
   end

   initial begin
      fault_count    = 0;
      cycle_count    = 0;
      steady         = 1'b0;
      hold_left      = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.data    = '0;
      xfer_state     = tre_pkg::ST_PENDING;
      next_block     = tre_pkg::FIRST_BLOCK;
      bytes_seen     = '0;
      size_lim       = tre_pkg::SIZE_LIMIT_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_ignored_packets();
      test_full_then_short();
      test_error_and_empty();
      test_size_limit();
      test_backpressure();
      test_random_transfers();

      // drain, then keep watching for anything stray
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fault_count == 0 && rsp_due.size() == 0) begin
         $display("tftp_receive_engine test passed");
      end else begin
         $display("tftp_receive_engine test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/tre_pkg.sv
sv/tre_ifs.sv
sv/tre_input_stage.sv
sv/tre_core.sv
sv/tftp_receive_engine.sv
sim/tb.sv
